// ===== design/art_pkg.sv =====
package art_pkg;

   // Table geometry and field widths.
   localparam int TABLE_ENTRIES = 16;
   localparam int SITE_BITS = 8;
   localparam int ROUTE_BITS = 16;
   localparam int LIFE_BITS = 16;
   localparam int STAMP_BITS = 16;
   localparam int OP_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS = 5;
   localparam int IDX_BITS = $clog2(TABLE_ENTRIES);

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_FIELD_BITS = 4 * SITE_BITS + ROUTE_BITS;
   localparam int REQ_DATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = SITE_BITS + COUNT_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Lifetime after reset: three times twenty thousand ticks.
   localparam logic [LIFE_BITS-1:0] LIFETIME_RESET = LIFE_BITS'(3 * 20000);

   // Operation codes.
   localparam logic [OP_BITS-1:0] OP_REGISTER = 2'd0;
   localparam logic [OP_BITS-1:0] OP_UNREGISTER = 2'd1;
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OP_BITS-1:0] OP_TICK = 2'd3;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } art_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } art_status_type;

endpackage

// ===== design/art_ctrl.sv =====
module art_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  art_pkg::art_status_type stat,
   output art_pkg::art_cmd_type    cmd
);
   import art_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Commit only once the result register can take the beat.
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/art_datapath.sv =====
module art_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  art_pkg::art_cmd_type                cmd,
   output art_pkg::art_status_type             stat,
   // Fields from bit 0: source_site, dest_site, route_number, prev_hop_site, next_hop_site.
   input  logic [art_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Fields from bit 0: opcode.
   input  logic [art_pkg::OP_BITS-1:0]         req_tuser,
   input  logic                                csr_wr_en,
   input  logic [art_pkg::LIFE_BITS-1:0]       csr_wr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: hop_site, expired_count, zero padding.
   output logic [art_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Fields from bit 0: status.
   output logic [art_pkg::STATUS_BITS-1:0]     rsp_tuser
);
   import art_pkg::*;

   // Request held for the whole operation.
   logic [OP_BITS-1:0]    op_ff;
   logic [SITE_BITS-1:0]  src_ff;
   logic [SITE_BITS-1:0]  dst_ff;
   logic [ROUTE_BITS-1:0] route_ff;
   logic [SITE_BITS-1:0]  prev_ff;
   logic [SITE_BITS-1:0]  next_ff;

   // Route table.
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [SITE_BITS-1:0]     src_tab_ff [TABLE_ENTRIES];
   logic [SITE_BITS-1:0]     src_tab_in [TABLE_ENTRIES];
   logic [SITE_BITS-1:0]     dst_tab_ff [TABLE_ENTRIES];
   logic [SITE_BITS-1:0]     dst_tab_in [TABLE_ENTRIES];
   logic [ROUTE_BITS-1:0]    route_tab_ff [TABLE_ENTRIES];
   logic [ROUTE_BITS-1:0]    route_tab_in [TABLE_ENTRIES];
   logic [SITE_BITS-1:0]     prev_tab_ff [TABLE_ENTRIES];
   logic [SITE_BITS-1:0]     prev_tab_in [TABLE_ENTRIES];
   logic [SITE_BITS-1:0]     next_tab_ff [TABLE_ENTRIES];
   logic [SITE_BITS-1:0]     next_tab_in [TABLE_ENTRIES];
   logic [LIFE_BITS-1:0]     life_tab_ff [TABLE_ENTRIES];
   logic [LIFE_BITS-1:0]     life_tab_in [TABLE_ENTRIES];
   logic [STAMP_BITS-1:0]    stamp_tab_ff [TABLE_ENTRIES];
   logic [STAMP_BITS-1:0]    stamp_tab_in [TABLE_ENTRIES];
   logic [STAMP_BITS-1:0]    stamp_count_ff, stamp_count_in;
   logic [LIFE_BITS-1:0]     lifetime_ff, lifetime_in;

   // Walk state.
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   best_ff, best_in;
   logic [STAMP_BITS-1:0] best_age_ff, best_age_in;
   logic                  rev_ff, rev_in;
   logic [SITE_BITS-1:0]  hop_ff, hop_in;
   logic [COUNT_BITS-1:0] expired_ff, expired_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [SITE_BITS-1:0]   rsp_hop_ff, rsp_hop_in;
   logic [COUNT_BITS-1:0]  rsp_expired_ff, rsp_expired_in;

   // Compare of the entry under the walk index.
   logic                  cur_valid;
   logic                  cur_route_eq;
   logic                  cur_fwd;
   logic                  cur_rev;
   logic                  cur_hit;
   logic [STAMP_BITS-1:0] cur_age;
   logic                  cur_better;

   always_comb begin
      cur_valid = valid_ff[idx_ff];
      cur_route_eq = route_tab_ff[idx_ff] == route_ff;
      cur_fwd = (src_tab_ff[idx_ff] == src_ff) && (dst_tab_ff[idx_ff] == dst_ff);
      cur_rev = (op_ff == OP_LOOKUP) && (src_tab_ff[idx_ff] == dst_ff)
                && (dst_tab_ff[idx_ff] == src_ff);
      cur_hit = cur_valid && cur_route_eq && (cur_fwd || cur_rev);
      cur_age = stamp_count_ff - stamp_tab_ff[idx_ff];
      cur_better = cur_hit && (!found_ff || (cur_age < best_age_ff));
   end

   assign stat.scan_last = idx_ff == IDX_BITS'(TABLE_ENTRIES - 1);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // Table, walk and result updates.
   always_comb begin
      valid_in = valid_ff;
      src_tab_in = src_tab_ff;
      dst_tab_in = dst_tab_ff;
      route_tab_in = route_tab_ff;
      prev_tab_in = prev_tab_ff;
      next_tab_in = next_tab_ff;
      life_tab_in = life_tab_ff;
      stamp_tab_in = stamp_tab_ff;
      stamp_count_in = stamp_count_ff;
      lifetime_in = csr_wr_en ? csr_wr_data : lifetime_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_age_in = best_age_ff;
      rev_in = rev_ff;
      hop_in = hop_ff;
      expired_in = expired_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_hop_in = rsp_hop_ff;
      rsp_expired_in = rsp_expired_ff;

      // Start of an operation: rewind the walk.
      if (cmd.load) begin
         idx_in = '0;
         found_in = 1'b0;
         expired_in = '0;
      end

      // One table entry per cycle.
      if (cmd.scan) begin
         idx_in = idx_ff + 1'b1;
         case (op_ff)
            OP_REGISTER: begin
               // Lowest free entry.
               if (!cur_valid && !found_ff) begin
                  found_in = 1'b1;
                  best_in = idx_ff;
               end
            end
            OP_UNREGISTER, OP_LOOKUP: begin
               // Newest matching entry; strict compare keeps the lower index on a tie.
               if (cur_better) begin
                  found_in = 1'b1;
                  best_in = idx_ff;
                  best_age_in = cur_age;
                  rev_in = !cur_fwd;
                  hop_in = cur_fwd ? next_tab_ff[idx_ff] : prev_tab_ff[idx_ff];
               end
            end
            OP_TICK: begin
               // Age the entry and drop it when its last tick runs out.
               if (cur_valid) begin
                  if (life_tab_ff[idx_ff] <= LIFE_BITS'(1)) begin
                     valid_in[idx_ff] = 1'b0;
                     expired_in = expired_ff + 1'b1;
                  end else begin
                     life_tab_in[idx_ff] = life_tab_ff[idx_ff] - 1'b1;
                  end
               end
            end
            default: begin
               idx_in = idx_ff + 1'b1;
            end
         endcase
      end

      // Commit the operation and load the result beat.
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_hop_in = '0;
         rsp_expired_in = '0;
         case (op_ff)
            OP_REGISTER: begin
               if (found_ff) begin
                  valid_in[best_ff] = 1'b1;
                  src_tab_in[best_ff] = src_ff;
                  dst_tab_in[best_ff] = dst_ff;
                  route_tab_in[best_ff] = route_ff;
                  prev_tab_in[best_ff] = prev_ff;
                  next_tab_in[best_ff] = next_ff;
                  life_tab_in[best_ff] = lifetime_ff;
                  stamp_tab_in[best_ff] = stamp_count_ff;
                  stamp_count_in = stamp_count_ff + 1'b1;
               end else begin
                  rsp_status_in = STATUS_FULL;
               end
            end
            OP_UNREGISTER: begin
               if (found_ff) begin
                  valid_in[best_ff] = 1'b0;
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            end
            OP_LOOKUP: begin
               if (found_ff) begin
                  rsp_hop_in = hop_ff;
                  // A forward hit restarts the route's lifetime.
                  if (!rev_ff) begin
                     life_tab_in[best_ff] = lifetime_ff;
                  end
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            end
            OP_TICK: begin
               rsp_expired_in = expired_ff;
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         stamp_count_ff <= '0;
         lifetime_ff <= LIFETIME_RESET;
         idx_ff <= '0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         stamp_count_ff <= stamp_count_in;
         lifetime_ff <= lifetime_in;
         idx_ff <= idx_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff <= req_tdata[SITE_BITS-1:0];
         dst_ff <= req_tdata[2*SITE_BITS-1:SITE_BITS];
         route_ff <= req_tdata[2*SITE_BITS+ROUTE_BITS-1:2*SITE_BITS];
         prev_ff <= req_tdata[3*SITE_BITS+ROUTE_BITS-1:2*SITE_BITS+ROUTE_BITS];
         next_ff <= req_tdata[4*SITE_BITS+ROUTE_BITS-1:3*SITE_BITS+ROUTE_BITS];
         op_ff <= req_tuser;
      end
      src_tab_ff <= src_tab_in;
      dst_tab_ff <= dst_tab_in;
      route_tab_ff <= route_tab_in;
      prev_tab_ff <= prev_tab_in;
      next_tab_ff <= next_tab_in;
      life_tab_ff <= life_tab_in;
      stamp_tab_ff <= stamp_tab_in;
      best_ff <= best_in;
      best_age_ff <= best_age_in;
      rev_ff <= rev_in;
      hop_ff <= hop_in;
      expired_ff <= expired_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hop_ff <= rsp_hop_in;
      rsp_expired_ff <= rsp_expired_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}}, rsp_expired_ff, rsp_hop_ff};

endmodule

// ===== design/aging_route_table.sv =====
// A result beat is registered: the request beat is loaded, the table is walked one entry per cycle,
// then a commit step loads the result register.
// A new request beat is taken only in idle, after the previous request has committed;
// a waiting result beat stalls only the commit of the following request, not its walk.
// Reset (synchronous, active high) empties the table, zeroes the insertion stamp
// and loads the lifetime register with 60000; there is no clearing pass.
module aging_route_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: source_site, dest_site, route_number, prev_hop_site, next_hop_site.
   input  logic [art_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Fields from bit 0: opcode.
   input  logic [art_pkg::OP_BITS-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: hop_site, expired_count, zero padding.
   output logic [art_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Fields from bit 0: status.
   output logic [art_pkg::STATUS_BITS-1:0]     rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [art_pkg::LIFE_BITS-1:0]       csr_wr_data
);
   import art_pkg::*;

   art_cmd_type    cmd;
   art_status_type stat;

   // Sequencer for load, walk and commit.
   art_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Route table, walk logic and result register.
   art_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import art_pkg::*;

   // Cycles to let pass once the last answer is in, a little over the
   // request-to-answer latency of the block.
   localparam int DRAIN_CYCLES = 24;
   localparam int KEY_POOL = 5;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 100;

   // One answer beat as the block reports it.
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [SITE_BITS-1:0]   hop;
      logic [COUNT_BITS-1:0]  expired;
   } route_answer_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [OP_BITS-1:0]       req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;
   logic                     csr_wr_en = 1'b0;
   logic [LIFE_BITS-1:0]     csr_wr_data = '0;

   aging_route_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the route table and the lifetime register.
   bit                  tbl_valid [TABLE_ENTRIES];
   bit [SITE_BITS-1:0]  tbl_src   [TABLE_ENTRIES];
   bit [SITE_BITS-1:0]  tbl_dst   [TABLE_ENTRIES];
   bit [ROUTE_BITS-1:0] tbl_route [TABLE_ENTRIES];
   bit [SITE_BITS-1:0]  tbl_prev  [TABLE_ENTRIES];
   bit [SITE_BITS-1:0]  tbl_next  [TABLE_ENTRIES];
   bit [LIFE_BITS-1:0]  tbl_life  [TABLE_ENTRIES];
   bit [STAMP_BITS-1:0] tbl_stamp [TABLE_ENTRIES];
   bit [STAMP_BITS-1:0] stamp_ctr = '0;
   bit [LIFE_BITS-1:0]  life_cfg = LIFETIME_RESET;

   route_answer_type pending_answers [$];

   bit calm = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned answer_count = 0;
   int unsigned sent_count = 0;
   int unsigned hit_count = 0;
   int unsigned full_count = 0;
   int unsigned aged_count = 0;
   int unsigned setting_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Newest valid route matching the key, optionally also with the sites
   // swapped. Returns -1 when nothing matches.
   function automatic int find_newest_route(input bit [SITE_BITS-1:0] src, dst,
                                            input bit [ROUTE_BITS-1:0] route,
                                            input bit allow_rev, output bit reversed);
      int best;
      bit [STAMP_BITS-1:0] best_age;
      bit [STAMP_BITS-1:0] age;
      bit fwd;
      bit rev;
      best = -1;
      best_age = '0;
      reversed = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!tbl_valid[i] || tbl_route[i] != route) continue;
         fwd = tbl_src[i] == src && tbl_dst[i] == dst;
         rev = allow_rev && tbl_src[i] == dst && tbl_dst[i] == src;
         if (!fwd && !rev) continue;
         age = stamp_ctr - tbl_stamp[i];
         // Strict compare keeps the lower index on equal age.
         if (best < 0 || age < best_age) begin
            best = i;
            best_age = age;
            reversed = !fwd;
         end
      end
      return best;
   endfunction

   // Apply one accepted request to the shadow table and queue its answer.
   task automatic predict_route_op(input bit [OP_BITS-1:0] op,
                                   input bit [SITE_BITS-1:0] src, dst,
                                   input bit [ROUTE_BITS-1:0] route,
                                   input bit [SITE_BITS-1:0] prev_hop, next_hop);
      route_answer_type ans;
      int slot;
      bit reversed;
      ans = '0;
      slot = -1;
      case (op)
         OP_REGISTER: begin
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
               if (!tbl_valid[i]) slot = i;
            if (slot < 0) begin
               ans.status = STATUS_FULL;
               full_count++;
            end else begin
               tbl_valid[slot] = 1'b1;
               tbl_src[slot] = src;
               tbl_dst[slot] = dst;
               tbl_route[slot] = route;
               tbl_prev[slot] = prev_hop;
               tbl_next[slot] = next_hop;
               tbl_life[slot] = life_cfg;
               tbl_stamp[slot] = stamp_ctr;
               stamp_ctr++;
            end
         end
         OP_UNREGISTER: begin
            slot = find_newest_route(src, dst, route, 1'b0, reversed);
            if (slot < 0) ans.status = STATUS_NOT_FOUND;
            else tbl_valid[slot] = 1'b0;
         end
         OP_LOOKUP: begin
            slot = find_newest_route(src, dst, route, 1'b1, reversed);
            if (slot < 0) begin
               ans.status = STATUS_NOT_FOUND;
            end else begin
               hit_count++;
               // Only a forward hit restarts the lifetime.
               if (reversed) begin
                  ans.hop = tbl_prev[slot];
               end else begin
                  ans.hop = tbl_next[slot];
                  tbl_life[slot] = life_cfg;
               end
            end
         end
         default: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!tbl_valid[i]) continue;
               if (tbl_life[i] <= 1) begin
                  tbl_valid[i] = 1'b0;
                  ans.expired++;
               end else begin
                  tbl_life[i]--;
               end
            end
            aged_count += ans.expired;
         end
      endcase
      ans.status = STATUS_OK | ans.status;
      pending_answers.push_back(ans);
   endtask

   // Send one request beat, with a random idle gap in front unless calm.
   task automatic send_route_op(input bit [OP_BITS-1:0] op,
                                input bit [SITE_BITS-1:0] src, dst,
                                input bit [ROUTE_BITS-1:0] route,
                                input bit [SITE_BITS-1:0] prev_hop, next_hop);
      int unsigned gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 33) gap = $urandom_range(1, 24);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {next_hop, prev_hop, route, dst, src};
      do @(posedge clock); while (!req_tready);
      predict_route_op(op, src, dst, route, prev_hop, next_hop);
      sent_count++;
   endtask

   // Stop sending and wait until the block has answered everything.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_lifetime(input bit [LIFE_BITS-1:0] value);
      drain_block();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      life_cfg = value;
      setting_count++;
   endtask

   task automatic note_mismatch(input string what, input logic [15:0] want_v,
                                input logic [15:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch on answer %0d, %s: expected %0h, got %0h",
                  answer_count, what, want_v, got_v);
   endtask

   // Empty table, extreme field values, newest-first order, a reverse hit
   // that is newer than the forward route, and a key with equal sites.
   task automatic test_route_ops();
      write_lifetime(16'd2);
      send_route_op(OP_LOOKUP, 8'd0, 8'd255, 16'd0, 8'd0, 8'd0);
      send_route_op(OP_UNREGISTER, 8'd0, 8'd255, 16'd0, 8'd0, 8'd0);
      send_route_op(OP_REGISTER, 8'd0, 8'd255, 16'd0, 8'd0, 8'd255);
      send_route_op(OP_REGISTER, 8'd255, 8'd0, 16'hFFFF, 8'd255, 8'd0);
      send_route_op(OP_LOOKUP, 8'd0, 8'd255, 16'd0, 8'd0, 8'd0);
      send_route_op(OP_LOOKUP, 8'd0, 8'd255, 16'hFFFF, 8'd0, 8'd0);
      send_route_op(OP_REGISTER, 8'd7, 8'd7, 16'd5, 8'd1, 8'd2);
      send_route_op(OP_LOOKUP, 8'd7, 8'd7, 16'd5, 8'd0, 8'd0);
      send_route_op(OP_REGISTER, 8'd255, 8'd0, 16'd0, 8'h5A, 8'hA5);
      send_route_op(OP_LOOKUP, 8'd0, 8'd255, 16'd0, 8'd0, 8'd0);
      send_route_op(OP_REGISTER, 8'd0, 8'd255, 16'd0, 8'h3C, 8'hC3);
      send_route_op(OP_LOOKUP, 8'd0, 8'd255, 16'd0, 8'd0, 8'd0);
      send_route_op(OP_UNREGISTER, 8'd0, 8'd255, 16'd0, 8'd0, 8'd0);
      send_route_op(OP_TICK, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0);
   endtask

   // Fill the table, overflow it once, then let one tick age out all entries.
   // Four routes are still held from the previous test.
   task automatic test_table_full();
      write_lifetime(16'd1);
      for (int i = 0; i < TABLE_ENTRIES - 4; i++)
         send_route_op(OP_REGISTER, SITE_BITS'($urandom), SITE_BITS'($urandom),
                       ROUTE_BITS'($urandom), SITE_BITS'($urandom), SITE_BITS'($urandom));
      send_route_op(OP_REGISTER, 8'd1, 8'd2, 16'd3, 8'd4, 8'd5);
      send_route_op(OP_TICK, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0);
   endtask

   // Random traffic over a small pool of keys per lifetime setting, so that
   // lookups and removals hit, with some fully random noise mixed in.
   task automatic test_random_traffic();
      bit [LIFE_BITS-1:0]  phase_life [PHASES];
      bit [SITE_BITS-1:0]  pool_src   [KEY_POOL];
      bit [SITE_BITS-1:0]  pool_dst   [KEY_POOL];
      bit [ROUTE_BITS-1:0] pool_route [KEY_POOL];
      int unsigned k;
      int unsigned roll;
      phase_life = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd5, 16'd0, 16'd2,
                     LIFETIME_RESET, 16'd0};
      phase_life[5] = LIFE_BITS'($urandom_range(4, 40));
      phase_life[8] = LIFE_BITS'($urandom);
      for (int phase = 0; phase < PHASES; phase++) begin
         write_lifetime(phase_life[phase]);
         calm = (phase == 4);
         for (int j = 0; j < KEY_POOL; j++) begin
            pool_src[j] = SITE_BITS'($urandom);
            pool_dst[j] = SITE_BITS'($urandom);
            pool_route[j] = ROUTE_BITS'($urandom);
         end
         // Equal sites on odd phases, and a second key that is the first reversed.
         if (phase % 2 == 1) pool_dst[0] = pool_src[0];
         pool_src[1] = pool_dst[0];
         pool_dst[1] = pool_src[0];
         pool_route[1] = pool_route[0];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            k = $urandom_range(0, KEY_POOL - 1);
            roll = $urandom_range(0, 99);
            if (roll < 10)
               send_route_op(OP_BITS'($urandom_range(0, 3)), SITE_BITS'($urandom),
                             SITE_BITS'($urandom), ROUTE_BITS'($urandom),
                             SITE_BITS'($urandom), SITE_BITS'($urandom));
            else if (roll < 35)
               send_route_op(OP_REGISTER, pool_src[k], pool_dst[k], pool_route[k],
                             SITE_BITS'($urandom), SITE_BITS'($urandom));
            else if (roll < 58)
               send_route_op(OP_LOOKUP, pool_src[k], pool_dst[k], pool_route[k],
                             SITE_BITS'($urandom), SITE_BITS'($urandom));
            else if (roll < 68)
               send_route_op(OP_LOOKUP, pool_dst[k], pool_src[k], pool_route[k],
                             SITE_BITS'($urandom), SITE_BITS'($urandom));
            else if (roll < 86)
               send_route_op(OP_UNREGISTER, pool_src[k], pool_dst[k], pool_route[k],
                             SITE_BITS'($urandom), SITE_BITS'($urandom));
            else
               send_route_op(OP_TICK, SITE_BITS'($urandom), SITE_BITS'($urandom),
                             ROUTE_BITS'($urandom), SITE_BITS'($urandom),
                             SITE_BITS'($urandom));
         end
      end
      calm = 1'b0;
   endtask

   // Answer-side backpressure: unless calm, ready drops in about a third of the cycles.
   always @(posedge clock) begin
      if (!calm && $urandom_range(0, 99) < 33) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every answer beat against the oldest prediction.
   always @(posedge clock) begin
      route_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answer_count++;
         if (pending_answers.size() == 0) begin
            note_mismatch("beat with no request pending", '0, '0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.status)
               note_mismatch("status", want.status, rsp_tuser);
            if (rsp_tdata[SITE_BITS-1:0] !== want.hop)
               note_mismatch("hop_site", want.hop, rsp_tdata[SITE_BITS-1:0]);
            if (rsp_tdata[SITE_BITS +: COUNT_BITS] !== want.expired)
               note_mismatch("expired_count", want.expired,
                             rsp_tdata[SITE_BITS +: COUNT_BITS]);
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_route_ops();
      test_table_full();
      test_random_traffic();
      drain_block();
      $display("Sent %0d requests under %0d lifetime settings: %0d lookup hits,",
               sent_count, setting_count, hit_count);
      $display("%0d full-table answers, %0d routes aged out, %0d mismatches.",
               full_count, aged_count, mismatch_count);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog against a hung handshake or missing answers.
   initial begin
      #5_000_000;
      $display("Timeout with %0d answers still pending", pending_answers.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/art_pkg.sv
design/art_ctrl.sv
design/art_datapath.sv
design/aging_route_table.sv
tb/tb.sv
